// ===== design/hsi_pkg.sv =====
// ----------------------------------------------------------------------------
// hsi_pkg
// Shared constants, types and remainder tables for the chained hash set.
// ----------------------------------------------------------------------------
package hsi_pkg;

    localparam int BUCKETS   = 101;
    localparam int ENTRIES   = 256;
    localparam int VAL_W     = 32;
    localparam int BYTE_W    = 8;
    localparam int NUM_BYTES = VAL_W / BYTE_W;
    localparam int BYTE_CNT  = 1 << BYTE_W;
    localparam int STEP_W    = (NUM_BYTES > 1) ? $clog2(NUM_BYTES) : 1;
    localparam int BKT_W     = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int CNT_W     = 9;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_PROBE  = 1'b1;

    typedef logic [BYTE_CNT-1:0][BKT_W-1:0] t_byte_tab;
    typedef logic [BUCKETS-1:0][BKT_W-1:0]  t_row_tab;

    typedef struct packed {
        logic [BKT_W-1:0] bucket;
        logic [IDX_W-1:0] ent_addr;
        logic             ins;
        logic [IDX_W-1:0] ins_idx;
        logic [VAL_W-1:0] ins_value;
    } t_store_req;

    typedef struct packed {
        logic             next_valid;
        logic [IDX_W-1:0] next_idx;
        logic [VAL_W-1:0] value;
    } t_entry;

    // byte value mod BUCKETS
    function automatic t_byte_tab f_byte_tab();
        t_byte_tab tab;
        int        acc;
        acc = 0;
        for (int i = 0; i < BYTE_CNT; i++) begin
            tab[i] = BKT_W'(acc);
            acc = acc + 1;
            if (acc == BUCKETS) begin
                acc = 0;
            end
        end
        return tab;
    endfunction

    // (partial remainder * 2^BYTE_W) mod BUCKETS
    function automatic t_row_tab f_row_tab();
        t_row_tab tab;
        int       step;
        int       acc;
        step = 0;
        for (int i = 0; i < BYTE_CNT; i++) begin
            step = step + 1;
            if (step == BUCKETS) begin
                step = 0;
            end
        end
        acc = 0;
        for (int r = 0; r < BUCKETS; r++) begin
            tab[r] = BKT_W'(acc);
            acc = acc + step;
            if (acc >= BUCKETS) begin
                acc = acc - BUCKETS;
            end
        end
        return tab;
    endfunction

    localparam t_byte_tab BYTE_MOD = f_byte_tab();
    localparam t_row_tab  ROW_MOD  = f_row_tab();

endpackage

// ===== design/hsi_mod_unit.sv =====
// ----------------------------------------------------------------------------
// hsi_mod_unit
// Bucket index unit: reduces a 32-bit magnitude mod BUCKETS, one byte a cycle.
// ----------------------------------------------------------------------------
module hsi_mod_unit
    import hsi_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [VAL_W-1:0] i_mag,
    output logic             o_busy,
    output logic [BKT_W-1:0] o_bucket
);

    logic [VAL_W-1:0]  r_mag,  n_mag;
    logic [BKT_W-1:0]  r_rem,  n_rem;
    logic [STEP_W-1:0] r_cnt,  n_cnt;
    logic              r_busy, n_busy;
    logic [BKT_W:0]    w_sum;

    always_comb begin
        w_sum  = {1'b0, ROW_MOD[r_rem]} + {1'b0, BYTE_MOD[r_mag[VAL_W-1 -: BYTE_W]]};
        n_mag  = r_mag;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        if (i_start) begin
            n_mag  = i_mag;
            n_rem  = '0;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_sum >= (BKT_W+1)'(BUCKETS)) begin
                n_rem = BKT_W'(w_sum - (BKT_W+1)'(BUCKETS));
            end else begin
                n_rem = w_sum[BKT_W-1:0];
            end
            n_mag = r_mag << BYTE_W;
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == STEP_W'(NUM_BYTES - 1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_mag <= n_mag;
        r_rem <= n_rem;
    end

    assign o_busy   = r_busy;
    assign o_bucket = r_rem;

endmodule

// ===== design/hsi_store.sv =====
// ----------------------------------------------------------------------------
// hsi_store
// Bucket head memory with valid flags and the entry memory of value and link.
// ----------------------------------------------------------------------------
module hsi_store
    import hsi_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_store_req       i_req,
    output logic             o_head_valid,
    output logic [IDX_W-1:0] o_head_idx,
    output t_entry           o_entry
);

    logic [IDX_W-1:0] head_mem [BUCKETS];
    t_entry           ent_mem  [ENTRIES];
    logic [BUCKETS-1:0] r_head_vld;
    logic             r_head_vld_q;
    logic [IDX_W-1:0] r_head_q;
    t_entry           r_ent_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_vld <= '0;
        end else if (i_req.ins) begin
            r_head_vld[i_req.bucket] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ins) begin
            head_mem[i_req.bucket] <= i_req.ins_idx;
        end
        r_head_q     <= head_mem[i_req.bucket];
        r_head_vld_q <= r_head_vld[i_req.bucket];
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ins) begin
            ent_mem[i_req.ins_idx] <= '{next_valid: r_head_vld_q,
                                        next_idx:   r_head_q,
                                        value:      i_req.ins_value};
        end
        r_ent_q <= ent_mem[i_req.ent_addr];
    end

    assign o_head_valid = r_head_vld_q;
    assign o_head_idx   = r_head_q;
    assign o_entry      = r_ent_q;

endmodule

// ===== design/hash_set_intersection.sv =====
// ----------------------------------------------------------------------------
// hash_set_intersection
// Chained hash set of signed 32-bit values for list intersection: insert
// adds a value once, probe reports membership and its place in the match list.
//
//   channel  direction  handshake           payload
//   input    in         i_valid / o_stall   i_command, i_item_value
//   output   out        o_valid / i_stall   o_result_value, o_hit, o_dropped,
//                                           o_match_index, o_match_count
//
// The result register loads after the input transfer has passed these steps, in
// order: byte-wise bucket
// reduction, a hand-off state, a head read, a first entry read, one
// compare per chain entry (none for an empty bucket), a commit. The next transfer is taken the cycle
// after commit, so a new item is not taken before the last one commits.
// Reset (synchronous, active low) empties all buckets and zeroes the counts.
// A stalled result holds in the output register; the next item is taken
// while it waits, and its commit waits until the register frees.
// ----------------------------------------------------------------------------
module hash_set_intersection
    import hsi_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic                    i_command,
    input  logic signed [VAL_W-1:0] i_item_value,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [VAL_W-1:0] o_result_value,
    output logic                    o_hit,
    output logic                    o_dropped,
    output logic [CNT_W-1:0]        o_match_index,
    output logic [CNT_W-1:0]        o_match_count
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_MOD   = 6'b000010,
        S_HEAD  = 6'b000100,
        S_FIRST = 6'b001000,
        S_CMP   = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state           r_state, n_state;
    logic             r_cmd;
    logic [VAL_W-1:0] r_value;
    logic             r_present, n_present;
    logic [CNT_W-1:0] r_used, n_used;
    logic [CNT_W-1:0] r_matches, n_matches;

    logic             r_out_valid, n_out_valid;
    logic [VAL_W-1:0] r_out_value, n_out_value;
    logic             r_out_hit, n_out_hit;
    logic             r_out_dropped, n_out_dropped;
    logic [CNT_W-1:0] r_out_mindex, n_out_mindex;
    logic [CNT_W-1:0] r_out_mcount, n_out_mcount;

    logic             w_accept;
    logic             w_commit;
    logic [VAL_W-1:0] w_mag;
    logic             mod_busy;
    logic [BKT_W-1:0] mod_bucket;
    t_store_req       store_req;
    logic             head_valid;
    logic [IDX_W-1:0] head_idx;
    t_entry           entry;

    assign o_stall  = (r_state != S_IDLE);
    assign w_accept = i_valid && !o_stall;
    assign w_mag    = i_item_value[VAL_W-1] ? (VAL_W'(0) - VAL_W'(i_item_value))
                                            : VAL_W'(i_item_value);
    assign w_commit = (r_state == S_DONE) && (!r_out_valid || !i_stall);

    hsi_mod_unit u_mod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_accept),
        .i_mag    (w_mag),
        .o_busy   (mod_busy),
        .o_bucket (mod_bucket)
    );

    always_comb begin
        store_req.bucket    = mod_bucket;
        store_req.ent_addr  = (r_state == S_FIRST) ? head_idx : entry.next_idx;
        store_req.ins       = w_commit && (r_cmd == CMD_INSERT) && !r_present &&
                              (r_used < CNT_W'(ENTRIES));
        store_req.ins_idx   = r_used[IDX_W-1:0];
        store_req.ins_value = r_value;
    end

    hsi_store u_store (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (store_req),
        .o_head_valid (head_valid),
        .o_head_idx   (head_idx),
        .o_entry      (entry)
    );

    always_comb begin
        n_state       = r_state;
        n_present     = r_present;
        n_used        = r_used;
        n_matches     = r_matches;
        n_out_valid   = r_out_valid;
        n_out_value   = r_out_value;
        n_out_hit     = r_out_hit;
        n_out_dropped = r_out_dropped;
        n_out_mindex  = r_out_mindex;
        n_out_mcount  = r_out_mcount;

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_present = 1'b0;
                    n_state   = S_MOD;
                end
            end
            S_MOD: begin
                if (!mod_busy) begin
                    n_state = S_HEAD;
                end
            end
            S_HEAD: begin
                n_state = S_FIRST;
            end
            S_FIRST: begin
                n_state = head_valid ? S_CMP : S_DONE;
            end
            S_CMP: begin
                if (entry.value == r_value) begin
                    n_present = 1'b1;
                    n_state   = S_DONE;
                end else if (!entry.next_valid) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_commit) begin
                    n_out_valid   = 1'b1;
                    n_out_value   = r_value;
                    n_out_hit     = r_present;
                    n_out_dropped = 1'b0;
                    n_out_mindex  = '0;
                    n_out_mcount  = r_matches;
                    if (r_cmd == CMD_INSERT) begin
                        if (!r_present) begin
                            if (r_used < CNT_W'(ENTRIES)) begin
                                n_used = r_used + 1'b1;
                            end else begin
                                n_out_dropped = 1'b1;
                            end
                        end
                    end else if (r_present) begin
                        n_out_mindex = r_matches;
                        if (r_matches < CNT_W'(ENTRIES)) begin
                            n_matches    = r_matches + 1'b1;
                            n_out_mcount = r_matches + 1'b1;
                        end
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_matches   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_matches   <= n_matches;
            r_out_valid <= n_out_valid;
        end
        if (w_accept) begin
            r_cmd   <= i_command;
            r_value <= VAL_W'(i_item_value);
        end
        r_present     <= n_present;
        r_out_value   <= n_out_value;
        r_out_hit     <= n_out_hit;
        r_out_dropped <= n_out_dropped;
        r_out_mindex  <= n_out_mindex;
        r_out_mcount  <= n_out_mcount;
    end

    assign o_valid        = r_out_valid;
    assign o_result_value = $signed(r_out_value);
    assign o_hit          = r_out_hit;
    assign o_dropped      = r_out_dropped;
    assign o_match_index  = r_out_mindex;
    assign o_match_count  = r_out_mcount;

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CNT_W'(ENTRIES))
        else $error("entry count beyond store size");

    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_dropped) |-> (r_used == CNT_W'(ENTRIES)))
        else $error("insert dropped while store has room");

    a_miss_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit) |-> (o_match_index == '0))
        else $error("match index on a miss");

    a_start_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_MOD) && mod_busy)
        else $error("bucket unit not started on transfer");

    a_hold_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && r_out_valid && i_stall) |=> (r_state == S_DONE))
        else $error("commit over a pending result");

endmodule
